// ===== hw/rtl/msb_first_bit_field_access_macros.svh =====
// Assertion macros used by the checker file of the bit field access block.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef MSB_FIRST_BIT_FIELD_ACCESS_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_ACCESS_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define MSBFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define MSBFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/msbfa_pkg.sv =====
// Package for the MSB-first bit field access block: widths, defaults, command codes.
// No dependencies.
package msbfa_pkg;

    localparam int CMD_W     = 3;
    localparam int CNT_W     = 6;
    localparam int DELTA_W   = 16;
    localparam int DATA_W    = 32;
    localparam int CURSOR_W  = 15;
    localparam int LEN_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 14;
    localparam int WIN_BYTES = 5;
    localparam int WIN_W     = WIN_BYTES * BYTE_W;

    localparam int STORE_BYTES_DEF    = 4096;
    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int LEN_RESET          = 4096;
    localparam int CURSOR_MAX         = 32767;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEEK_BITS   = 3'd0,
        CMD_SEEK_BYTES  = 3'd1,
        CMD_READ_FIELD  = 3'd2,
        CMD_READ_SIGNED = 3'd3,
        CMD_WRITE_FIELD = 3'd4,
        CMD_READ_BYTE   = 3'd5,
        CMD_WRITE_BYTE  = 3'd6
    } cmd_t;

endpackage

// ===== hw/rtl/msbfa_cmd_if.sv =====
// Command channel interface: valid/ready plus one command transaction.
// Depends on msbfa_pkg.
interface msbfa_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [msbfa_pkg::CMD_W-1:0]         command;
    logic [msbfa_pkg::CNT_W-1:0]         bit_count;
    logic signed [msbfa_pkg::DELTA_W-1:0] seek_delta;
    logic [msbfa_pkg::DATA_W-1:0]        write_value;
    logic                                last_of_transfer;

    modport source (
        output valid, command, bit_count, seek_delta, write_value, last_of_transfer,
        input  ready
    );
    modport sink (
        input  valid, command, bit_count, seek_delta, write_value, last_of_transfer,
        output ready
    );
endinterface

// ===== hw/rtl/msbfa_res_if.sv =====
// Result channel interface: valid/ready plus one result transaction.
// Depends on msbfa_pkg.
interface msbfa_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [msbfa_pkg::DATA_W-1:0]         field_value;
    logic signed [msbfa_pkg::DATA_W-1:0]  signed_field;
    logic [msbfa_pkg::CURSOR_W-1:0]       cursor_after;
    logic                                 transfer_done;

    modport source (
        output valid, field_value, signed_field, cursor_after, transfer_done,
        input  ready
    );
    modport sink (
        input  valid, field_value, signed_field, cursor_after, transfer_done,
        output ready
    );
endinterface

// ===== hw/rtl/msb_first_bit_field_access.sv =====
// Top level of the MSB-first bit field access block: byte store, bit cursor, sequencer.
// Depends on msbfa_pkg, msbfa_cmd_if and msbfa_res_if.
//
//  channel | kind            | handshake         | carries
//  --------+-----------------+-------------------+----------------------------------------
//  cmd     | in, interface   | valid/ready       | command, bit_count, seek_delta, ...
//  res     | out, interface  | valid/ready       | field_value, signed_field, cursor_after, transfer_done
//  cfg     | in, write only  | cfg_wr_en         | stream_length_bytes (cfg_wr_data)
//
// Field and byte commands pass S_ACCESS, reads then S_EXTRACT, and all end in S_FINISH; seeks
// and the unused command go straight to S_FINISH. A field spans nb (1..5) bytes. The
// byte-wide store read and write ports each move one byte per cycle.
// After reset the store is swept to zero, one byte per cycle, with cmd.ready low. A finished
// result sits in the output register; the next command is taken meanwhile, and the finish
// step holds while that register is full and res.ready is low.
module msb_first_bit_field_access #(
    parameter int STORE_BYTES    = msbfa_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = msbfa_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [msbfa_pkg::LEN_W-1:0] cfg_wr_data,
    msbfa_cmd_if.sink                   cmd,
    msbfa_res_if.source                 res
);

    localparam int ADDR_W   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LEN_W    = msbfa_pkg::LEN_W;
    localparam int CNT_W    = msbfa_pkg::CNT_W;
    localparam int DATA_W   = msbfa_pkg::DATA_W;
    localparam int CURSOR_W = msbfa_pkg::CURSOR_W;
    localparam int IDX_W    = msbfa_pkg::IDX_W;
    localparam int BYTE_W   = msbfa_pkg::BYTE_W;
    localparam int WIN_W    = msbfa_pkg::WIN_W;
    localparam int DELTA_W  = msbfa_pkg::DELTA_W;
    localparam int CMD_W    = msbfa_pkg::CMD_W;
    localparam int SUM_W    = 21;   // signed cursor sum: aligned cursor + 8 * delta

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_ACCESS  = 5'b00100,
        S_EXTRACT = 5'b01000,
        S_FINISH  = 5'b10000
    } state_t;

    // control state
    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    logic [LEN_W-1:0]          len_reg;
    logic [CURSOR_W-1:0]       cursor_reg, cursor_next;
    logic [2:0]                issue_reg, issue_next;
    logic                      pend_reg, pend_next;
    logic [2:0]                pend_k_reg, pend_k_next;
    logic                      res_valid_reg, res_valid_next;

    // latched command and working data
    logic [CMD_W-1:0]          op_reg, op_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [2:0]                off_reg, off_next;
    logic [IDX_W-1:0]          base_reg, base_next;
    logic [2:0]                nbytes_reg, nbytes_next;
    logic [CURSOR_W:0]         align_reg, align_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic                      last_reg, last_next;
    logic [WIN_W-1:0]          pattern_reg, pattern_next;
    logic [WIN_W-1:0]          window_reg, window_next;
    logic [DATA_W-1:0]         field_reg, field_next;

    // output register
    logic [DATA_W-1:0]         res_fv_reg, res_fv_next;
    logic [DATA_W-1:0]         res_sv_reg, res_sv_next;
    logic [CURSOR_W-1:0]       res_cur_reg, res_cur_next;
    logic                      res_done_reg, res_done_next;

    // byte store, one write and one registered read port
    logic [BYTE_W-1:0]         mem [STORE_BYTES];
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [BYTE_W-1:0]         mem_wdata;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [BYTE_W-1:0]         rd_data_reg;

    // length bounds
    logic [LEN_W-1:0]          eff_len;
    logic [LEN_W+2:0]          len_bits_m1;
    logic [CURSOR_W-1:0]       last_bit;

    // accept-side helpers
    logic [CNT_W-1:0]          in_n;
    logic [2:0]                in_off;
    logic [CURSOR_W:0]         in_align;
    logic [CNT_W:0]            in_span;
    logic [2:0]                in_nb;
    logic [DATA_W-1:0]         in_val;
    logic [WIN_W-1:0]          in_pat;

    // access-side helpers
    logic [IDX_W-1:0]          wr_idx;
    logic                      wr_in_rng;
    logic [BYTE_W-1:0]         rd_byte;
    logic [BYTE_W-1:0]         pat_byte;
    logic                      op_is_wr;
    logic                      op_is_rd;

    // finish-side helpers
    logic [WIN_W-1:0]          win_shift;
    logic [4:0]                sign_idx;
    logic [DATA_W-1:0]         sext_val;
    logic signed [SUM_W-1:0]   cur_sum;
    logic [CURSOR_W-1:0]       cur_clamped;
    logic                      finish_go;

    // a zero length acts as one byte, anything above the store as the store size
    always_comb
    begin
        if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(len_reg) > STORE_BYTES)
            eff_len = LEN_W'(STORE_BYTES);
        else
            eff_len = len_reg;
        len_bits_m1 = {eff_len, 3'b000} - (LEN_W+3)'(1);
        if (len_bits_m1 > (LEN_W+3)'(msbfa_pkg::CURSOR_MAX))
            last_bit = CURSOR_W'(msbfa_pkg::CURSOR_MAX);
        else
            last_bit = len_bits_m1[CURSOR_W-1:0];
    end

    // field geometry and write pattern for a command at the port
    always_comb
    begin
        if (cmd.bit_count > CNT_W'(MAX_FIELD_BITS))
            in_n = CNT_W'(MAX_FIELD_BITS);
        else
            in_n = cmd.bit_count;
        in_off   = cursor_reg[2:0];
        in_align = (cursor_reg[2:0] != 3'd0)
                 ? ({1'b0, cursor_reg[CURSOR_W-1:3], 3'b000} + (CURSOR_W+1)'(8))
                 : {1'b0, cursor_reg};
        in_span  = (CNT_W+1)'(in_off) + (CNT_W+1)'(in_n) + (CNT_W+1)'(7);
        in_nb    = (in_span[5:3] == 3'd0) ? 3'd1 : in_span[5:3];
        in_val   = cmd.write_value & ~({DATA_W{1'b1}} << in_n);
        // first field bit lands at window bit WIN_W-1-offset
        in_pat   = ({in_val, {(WIN_W-DATA_W){1'b0}}} << (CNT_W'(DATA_W) - in_n)) >> in_off;
    end

    always_comb
    begin
        op_is_wr = (op_reg == msbfa_pkg::CMD_WRITE_FIELD) || (op_reg == msbfa_pkg::CMD_WRITE_BYTE);
        op_is_rd = (op_reg == msbfa_pkg::CMD_READ_FIELD) || (op_reg == msbfa_pkg::CMD_READ_SIGNED)
                || (op_reg == msbfa_pkg::CMD_READ_BYTE);
        wr_idx    = base_reg + IDX_W'(pend_k_reg);
        wr_in_rng = wr_idx < IDX_W'(eff_len);
        rd_byte   = wr_in_rng ? rd_data_reg : '0;
        pat_byte  = '0;
        for (int j = 0; j < msbfa_pkg::WIN_BYTES; j++)
        begin
            if (pend_k_reg == 3'(j))
                pat_byte = pattern_reg[WIN_W-1-BYTE_W*j -: BYTE_W];
        end
    end

    // sign extension and new cursor, used in the finish step
    always_comb
    begin
        win_shift = window_reg << off_reg;
        sign_idx  = 5'(n_reg - CNT_W'(1));
        if ((n_reg != '0) && (n_reg < CNT_W'(DATA_W)) && field_reg[sign_idx])
            sext_val = field_reg | ({DATA_W{1'b1}} << n_reg);
        else
            sext_val = field_reg;

        case (op_reg)
            msbfa_pkg::CMD_SEEK_BITS:
                cur_sum = $signed({{(SUM_W-CURSOR_W){1'b0}}, cursor_reg})
                        + $signed({{(SUM_W-DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg});
            msbfa_pkg::CMD_SEEK_BYTES:
                cur_sum = $signed({{(SUM_W-CURSOR_W-1){1'b0}}, align_reg})
                        + $signed({{(SUM_W-DELTA_W-3){delta_reg[DELTA_W-1]}}, delta_reg, 3'b000});
            default:
                cur_sum = $signed({{(SUM_W-CURSOR_W-1){1'b0}}, align_reg}) + SUM_W'(8);
        endcase

        if (cur_sum[SUM_W-1])
            cur_clamped = '0;
        else if (cur_sum[SUM_W-2:0] > (SUM_W-1)'(last_bit))
            cur_clamped = last_bit;
        else
            cur_clamped = cur_sum[CURSOR_W-1:0];

        finish_go = !res_valid_reg || res.ready;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cursor_next    = cursor_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_k_next    = pend_k_reg;
        res_valid_next = res_valid_reg && !res.ready;
        op_next        = op_reg;
        n_next         = n_reg;
        off_next       = off_reg;
        base_next      = base_reg;
        nbytes_next    = nbytes_reg;
        align_next     = align_reg;
        delta_next     = delta_reg;
        last_next      = last_reg;
        pattern_next   = pattern_reg;
        window_next    = window_reg;
        field_next     = field_reg;
        res_fv_next    = res_fv_reg;
        res_sv_next    = res_sv_reg;
        res_cur_next   = res_cur_reg;
        res_done_next  = res_done_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(wr_idx);
        mem_wdata      = rd_data_reg | pat_byte;
        mem_raddr      = ADDR_W'(base_reg + IDX_W'(issue_reg));

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_BYTES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next     = cmd.command;
                    delta_next  = cmd.seek_delta;
                    last_next   = cmd.last_of_transfer;
                    align_next  = in_align;
                    window_next = '0;
                    issue_next  = '0;
                    unique case (cmd.command) inside
                        msbfa_pkg::CMD_READ_FIELD, msbfa_pkg::CMD_READ_SIGNED,
                        msbfa_pkg::CMD_WRITE_FIELD:
                        begin
                            base_next    = IDX_W'(cursor_reg[CURSOR_W-1:3]);
                            off_next     = in_off;
                            n_next       = in_n;
                            nbytes_next  = in_nb;
                            pattern_next = in_pat;
                            state_next   = S_ACCESS;
                        end
                        msbfa_pkg::CMD_READ_BYTE, msbfa_pkg::CMD_WRITE_BYTE:
                        begin
                            base_next    = IDX_W'(in_align[CURSOR_W:3]);
                            off_next     = 3'd0;
                            n_next       = CNT_W'(BYTE_W);
                            nbytes_next  = 3'd1;
                            pattern_next = {cmd.write_value[BYTE_W-1:0],
                                            {(WIN_W-BYTE_W){1'b0}}};
                            state_next   = S_ACCESS;
                        end
                        default:
                            state_next = S_FINISH;   // seeks and the unused code
                    endcase
                end
            end
            S_ACCESS:
            begin
                // one byte read issued per cycle, data back in the next cycle
                if (issue_reg < nbytes_reg)
                begin
                    issue_next  = issue_reg + 3'd1;
                    pend_next   = 1'b1;
                    pend_k_next = issue_reg;
                end
                if (pend_reg)
                begin
                    for (int j = 0; j < msbfa_pkg::WIN_BYTES; j++)
                    begin
                        if (pend_k_reg == 3'(j))
                            window_next[WIN_W-1-BYTE_W*j -: BYTE_W] = rd_byte;
                    end
                    // OR write-back; addresses within one command never repeat
                    mem_we = op_is_wr && wr_in_rng;
                    if (pend_k_reg == nbytes_reg - 3'd1)
                        state_next = op_is_rd ? S_EXTRACT : S_FINISH;
                end
            end
            S_EXTRACT:
            begin
                field_next = win_shift[WIN_W-1 -: DATA_W] >> (CNT_W'(DATA_W) - n_reg);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    res_valid_next = 1'b1;
                    res_done_next  = last_reg;
                    res_fv_next    = '0;
                    res_sv_next    = '0;
                    case (op_reg) inside
                        msbfa_pkg::CMD_READ_FIELD, msbfa_pkg::CMD_READ_SIGNED:
                        begin
                            res_fv_next = field_reg;
                            res_sv_next = sext_val;
                        end
                        msbfa_pkg::CMD_READ_BYTE:
                            res_fv_next = field_reg;
                        default:
                            res_fv_next = '0;
                    endcase
                    case (op_reg) inside
                        msbfa_pkg::CMD_SEEK_BITS, msbfa_pkg::CMD_SEEK_BYTES,
                        msbfa_pkg::CMD_READ_BYTE, msbfa_pkg::CMD_WRITE_BYTE:
                            cursor_next = cur_clamped;
                        default:
                            cursor_next = cursor_reg;
                    endcase
                    res_cur_next = (op_reg == msbfa_pkg::CMD_SEEK_BITS)
                                || (op_reg == msbfa_pkg::CMD_SEEK_BYTES)
                                || (op_reg == msbfa_pkg::CMD_READ_BYTE)
                                || (op_reg == msbfa_pkg::CMD_WRITE_BYTE)
                                 ? cur_clamped : cursor_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            len_reg       <= LEN_W'(msbfa_pkg::LEN_RESET);
            cursor_reg    <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_k_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cursor_reg    <= cursor_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_k_reg    <= pend_k_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
                len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        n_reg        <= n_next;
        off_reg      <= off_next;
        base_reg     <= base_next;
        nbytes_reg   <= nbytes_next;
        align_reg    <= align_next;
        delta_reg    <= delta_next;
        last_reg     <= last_next;
        pattern_reg  <= pattern_next;
        window_reg   <= window_next;
        field_reg    <= field_next;
        res_fv_reg   <= res_fv_next;
        res_sv_reg   <= res_sv_next;
        res_cur_reg  <= res_cur_next;
        res_done_reg <= res_done_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.field_value   = res_fv_reg;
    assign res.signed_field  = res_sv_reg;
    assign res.cursor_after  = res_cur_reg;
    assign res.transfer_done = res_done_reg;

endmodule

// ===== hw/rtl/msbfa_checker.sv =====
// Port-level checker for the bit field access block, bound to the top level.
// Depends on msbfa_pkg and msb_first_bit_field_access_macros.svh.
`include "msb_first_bit_field_access_macros.svh"

module msbfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [msbfa_pkg::DATA_W-1:0]   res_field_value,
    input logic [msbfa_pkg::DATA_W-1:0]   res_signed_field,
    input logic [msbfa_pkg::CURSOR_W-1:0] res_cursor_after,
    input logic                           res_transfer_done
);

    // a stalled result holds its payload
    `MSBFA_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_field_value) && $stable(res_signed_field) && $stable(res_cursor_after) && $stable(res_transfer_done), "result changed while stalled")

    // one command at a time: ready drops after each accepted transaction
    `MSBFA_ASSERT_NXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready, "command accepted back to back")

    // a sign-extended field only adds upper ones to the unsigned field
    `MSBFA_ASSERT_IMP(a_sext_cover, res_valid && (res_signed_field != '0), (res_signed_field & res_field_value) == res_field_value, "signed field disagrees with field")

endmodule

bind msb_first_bit_field_access msbfa_checker u_msbfa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_field_value   (res.field_value),
    .res_signed_field  (res.signed_field),
    .res_cursor_after  (res.cursor_after),
    .res_transfer_done (res.transfer_done)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for msb_first_bit_field_access: a scoreboard class mirrors the
// byte store and bit cursor, tasks drive commands and length writes, and an always block
// drives result stalls. Depends on msbfa_pkg, msbfa_cmd_if, msbfa_res_if and the block.
module tb_top;

    localparam int CMD_W              = msbfa_pkg::CMD_W;
    localparam int CNT_W              = msbfa_pkg::CNT_W;
    localparam int DELTA_W            = msbfa_pkg::DELTA_W;
    localparam int DATA_W             = msbfa_pkg::DATA_W;
    localparam int CURSOR_W           = msbfa_pkg::CURSOR_W;
    localparam int BYTE_W             = msbfa_pkg::BYTE_W;
    localparam int LEN_W              = msbfa_pkg::LEN_W;
    localparam int STORE_BYTES_DEF    = msbfa_pkg::STORE_BYTES_DEF;
    localparam int MAX_FIELD_BITS_DEF = msbfa_pkg::MAX_FIELD_BITS_DEF;
    localparam int LEN_RESET          = msbfa_pkg::LEN_RESET;
    localparam int CURSOR_MAX         = msbfa_pkg::CURSOR_MAX;

    // Command 7 has no name in the package; the block must treat it as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // Quiet cycles allowed before the run is declared hung. The post-reset store sweep
    // (with cmd.ready low throughout) is the longest legal silence by far.
    localparam int unsigned QUIET_LIMIT  = 20000;
    // Settling time after the last result, so a stray extra result still gets caught.
    localparam int          SETTLE_CYCLES = 20;

    typedef struct {
        logic [CMD_W-1:0]          command;
        logic [CNT_W-1:0]          bit_count;
        logic signed [DELTA_W-1:0] seek_delta;
        logic [DATA_W-1:0]         write_value;
        logic                      last_of_transfer;
    } cmd_item_t;

    typedef struct {
        logic [DATA_W-1:0]        field_value;
        logic signed [DATA_W-1:0] signed_field;
        logic [CURSOR_W-1:0]      cursor_after;
        logic                     transfer_done;
    } field_result_t;

    // Receiver ready patterns; the result side switches among them at random.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_SPARSE,
        RX_COIN,
        RX_LONG_STALL
    } rx_pattern_t;

    // ------------------------------------------------------------------------------------
    // Scoreboard: mirror of the store, cursor and length register; predicts one result per
    // accepted command and checks results in order.
    // ------------------------------------------------------------------------------------
    class bitfield_scoreboard;
        bit [BYTE_W-1:0] store_mirror [STORE_BYTES_DEF];
        int unsigned     cursor;
        int unsigned     length_reg;
        field_result_t   field_results_q [$];
        int unsigned     mismatch_count;

        function new();
            cursor         = 0;
            length_reg     = LEN_RESET;
            mismatch_count = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            length_reg = 32'(value);
        endfunction

        // 0 acts as 1, anything past the store acts as the store size
        function int unsigned valid_bytes();
            int unsigned n;
            n = length_reg;
            if (n == 0)
                n = 1;
            if (n > STORE_BYTES_DEF)
                n = STORE_BYTES_DEF;
            return n;
        endfunction

        function int unsigned clamp_cursor(int pos);
            int unsigned top;
            top = valid_bytes() * 8 - 1;
            if (top > CURSOR_MAX)
                top = CURSOR_MAX;
            if (pos < 0)
                return 0;
            if (pos > int'(top))
                return top;
            return pos;
        endfunction

        function int unsigned outstanding();
            return field_results_q.size();
        endfunction

        function void note_command(cmd_item_t it);
            field_result_t r;
            int unsigned   nbits;
            int unsigned   aligned;
            int unsigned   idx;
            int unsigned   p;
            int            i;
            r.field_value   = '0;
            r.signed_field  = '0;
            nbits   = (it.bit_count > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : it.bit_count;
            // byte commands and byte seeks round an unaligned cursor up first
            aligned = (cursor & 7) ? ((cursor | 7) + 1) : cursor;
            idx     = aligned >> 3;
            case (it.command) inside
                msbfa_pkg::CMD_SEEK_BITS:
                    cursor = clamp_cursor(int'(cursor) + int'(it.seek_delta));
                msbfa_pkg::CMD_SEEK_BYTES:
                    cursor = clamp_cursor(int'(aligned) + 8 * int'(it.seek_delta));
                msbfa_pkg::CMD_READ_FIELD, msbfa_pkg::CMD_READ_SIGNED:
                begin
                    // first stream bit lands in the field's MSB (bit nbits-1); bits past the end read 0
                    for (i = 0; i < nbits; i++)
                    begin
                        p = cursor + i;
                        r.field_value = {r.field_value[DATA_W-2:0],
                            (p < valid_bytes() * 8) && store_mirror[p >> 3][7 - (p & 7)]};
                    end
                    r.signed_field = r.field_value;
                    if (nbits > 0 && nbits < DATA_W && r.field_value[nbits-1])
                        r.signed_field = r.field_value | (32'hFFFF_FFFF << nbits);
                end
                msbfa_pkg::CMD_WRITE_FIELD:
                begin
                    // OR-only write, cursor stays put
                    for (i = 0; i < nbits; i++)
                    begin
                        p = cursor + i;
                        if (it.write_value[nbits-1-i] && p < valid_bytes() * 8)
                            store_mirror[p >> 3][7 - (p & 7)] = 1'b1;
                    end
                end
                msbfa_pkg::CMD_READ_BYTE:
                begin
                    if (idx < valid_bytes())
                        r.field_value = DATA_W'(store_mirror[idx]);
                    cursor = clamp_cursor(int'(aligned) + 8);
                end
                msbfa_pkg::CMD_WRITE_BYTE:
                begin
                    if (idx < valid_bytes())
                        store_mirror[idx] = store_mirror[idx] | it.write_value[BYTE_W-1:0];
                    cursor = clamp_cursor(int'(aligned) + 8);
                end
                default:
                    ;
            endcase
            r.cursor_after  = cursor[CURSOR_W-1:0];
            r.transfer_done = it.last_of_transfer;
            field_results_q.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] fv, logic signed [DATA_W-1:0] sf,
                                   logic [CURSOR_W-1:0] cur, logic done);
            field_result_t e;
            if (field_results_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending: fv=%h sf=%h cursor=%0d done=%b",
                             $realtime, fv, sf, cur, done);
                return;
            end
            e = field_results_q.pop_front();
            if (fv !== e.field_value || sf !== e.signed_field ||
                cur !== e.cursor_after || done !== e.transfer_done)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: result mismatch exp fv=%h sf=%h cursor=%0d done=%b",
                              " / got fv=%h sf=%h cursor=%0d done=%b"},
                             $realtime, e.field_value, e.signed_field, e.cursor_after,
                             e.transfer_done, fv, sf, cur, done);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    msbfa_cmd_if cmd_ch ();
    msbfa_res_if res_ch ();

    bitfield_scoreboard sb = new();

    int unsigned burst_left  = 0;   // transactions left before the sender takes a break
    int unsigned quiet_cycles = 0;  // cycles since the last handshake on either channel
    int unsigned stall_tick  = 0;
    rx_pattern_t stall_mode  = RX_ALWAYS;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    msb_first_bit_field_access u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .res         (res_ch)
    );

    // ------------------------------------------------------------------------------------
    // Result side: check every accepted transaction, then pick the next ready value from
    // the current stall pattern. Long always-ready stretches come from RX_ALWAYS.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.field_value, res_ch.signed_field,
                            res_ch.cursor_after, res_ch.transfer_done);
        stall_tick <= stall_tick + 1;
        if (stall_tick % 128 == 0)
            stall_mode <= rx_pattern_t'($urandom_range(0, 3));
        case (stall_mode)
            RX_ALWAYS:     res_ch.ready <= 1'b1;
            RX_SPARSE:     res_ch.ready <= (stall_tick % 4 == 0);
            RX_COIN:       res_ch.ready <= 1'($urandom_range(0, 1));
            RX_LONG_STALL: res_ch.ready <= (stall_tick % 32) >= 12;
            default:       res_ch.ready <= 1'b1;
        endcase
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------------------
    function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] c, logic [CNT_W-1:0] n,
                                           logic signed [DELTA_W-1:0] d,
                                           logic [DATA_W-1:0] v, logic last);
        cmd_item_t it;
        it.command          = c;
        it.bit_count        = n;
        it.seek_delta       = d;
        it.write_value      = v;
        it.last_of_transfer = last;
        return it;
    endfunction

    // Mostly short seeks so the cursor wanders over written data; some full-range and
    // extreme deltas to hit both clamps; occasional over-wide counts and command 7.
    function automatic cmd_item_t random_cmd();
        cmd_item_t   it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it.command = (pick < 3) ? CMD_UNUSED : CMD_W'($urandom_range(0, 6));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.bit_count = CNT_W'($urandom_range(33, 63));
        else if (pick == 1)
            it.bit_count = CNT_W'(MAX_FIELD_BITS_DEF);
        else
            it.bit_count = CNT_W'($urandom_range(0, 32));
        pick = $urandom_range(0, 19);
        if (pick < 14)
            it.seek_delta = DELTA_W'($urandom_range(0, 48) - 24);  // wraps to a small move
        else if (pick < 18)
            it.seek_delta = DELTA_W'($urandom());
        else
            it.seek_delta = (pick == 18) ? 16'sh8000 : 16'sh7FFF;
        it.write_value      = $urandom();
        it.last_of_transfer = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Drive one transaction, wait for the handshake, then maybe take a break.
    // valid is never lowered here unless a gap follows before the next transaction.
    task automatic send_cmd(cmd_item_t it);
        cmd_ch.valid            <= 1'b1;
        cmd_ch.command          <= it.command;
        cmd_ch.bit_count        <= it.bit_count;
        cmd_ch.seek_delta       <= it.seek_delta;
        cmd_ch.write_value      <= it.write_value;
        cmd_ch.last_of_transfer <= it.last_of_transfer;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(it);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // now and then a long back-to-back stretch
            burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(0, 12);
        end
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Length writes only happen with the block idle.
    task automatic write_stream_length(logic [LEN_W-1:0] value);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_length(value);
    endtask

    // Random phase: a quarter of the time a write/read/signed-read triple on the same
    // field (the cursor does not move across field commands), otherwise a random command.
    task automatic run_random_phase(int unsigned count);
        int unsigned sent;
        int unsigned nb;
        logic [DATA_W-1:0] v;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                nb = $urandom_range(1, 32);
                v  = $urandom();
                send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_FIELD, CNT_W'(nb),
                                  DELTA_W'($urandom()), v, 1'b0));
                send_cmd(make_cmd(msbfa_pkg::CMD_READ_FIELD, CNT_W'(nb),
                                  DELTA_W'($urandom()), $urandom(), 1'b0));
                send_cmd(make_cmd(msbfa_pkg::CMD_READ_SIGNED, CNT_W'(nb),
                                  DELTA_W'($urandom()), $urandom(), 1'b1));
                sent += 3;
            end
            else
            begin
                send_cmd(random_cmd());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = '0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.command          = '0;
        cmd_ch.bit_count        = '0;
        cmd_ch.seek_delta       = '0;
        cmd_ch.write_value      = '0;
        cmd_ch.last_of_transfer = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset length (4096 bytes). The first command simply waits
        // out the store sweep on cmd.ready.
        // cleared store
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_FIELD,  32, 0, 0, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_FIELD, 32, 0, 32'hA5C3_0F81, 1'b1));
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_FIELD,  32, 0, 0, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_SIGNED, 32, 0, 0, 1'b1));
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_SIGNED, 5, 0, 0, 1'b0));   // negative field
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_FIELD,  0, 0, 0, 1'b0));   // zero width
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_SIGNED, 63, 0, 0, 1'b1));  // over-wide count
        // zero width writes nothing
        send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_FIELD, 0, 0, 32'hFFFF_FFFF, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_FIELD, 40, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_SEEK_BITS,   0, 3, 0, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_FIELD,  13, 0, 0, 1'b1));  // unaligned field
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_BYTE,   0, 0, 0, 1'b0));   // aligns up first
        // OR, low byte only
        send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_BYTE,  0, 0, 32'hFFFF_FF5A, 1'b1));
        send_cmd(make_cmd(msbfa_pkg::CMD_SEEK_BYTES,  0, -16'sd1, 0, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_BYTE,   0, 0, 0, 1'b0));
        // saturates at 0, then at the last bit
        send_cmd(make_cmd(msbfa_pkg::CMD_SEEK_BITS,   0, 16'sh8000, 0, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_SEEK_BITS,   0, 16'sh7FFF, 0, 1'b1));
        send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_FIELD, 8, 0, 32'hFF, 1'b0)); // last bit only
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_FIELD,  32, 0, 0, 1'b0));  // bits past the end read zero
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_SIGNED, 1, 0, 0, 1'b1));
        send_cmd(make_cmd(msbfa_pkg::CMD_READ_BYTE,   0, 0, 0, 1'b0));   // aligned past end
        send_cmd(make_cmd(msbfa_pkg::CMD_WRITE_BYTE,  0, 0, 32'hFFFF_FFFF, 1'b0));
        send_cmd(make_cmd(msbfa_pkg::CMD_SEEK_BYTES,  0, 16'sh8000, 0, 1'b1));
        send_cmd(make_cmd(msbfa_pkg::CMD_SEEK_BYTES,  0, 16'sh7FFF, 0, 1'b0));
        send_cmd(make_cmd(CMD_UNUSED, 63, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1));

        // Random phases over several lengths: zero (acts as one byte), one byte, the
        // largest code (acts as the full store), small windows, and the full store.
        write_stream_length(13'd0);
        run_random_phase(40);
        write_stream_length(13'd1);
        run_random_phase(30);
        write_stream_length(13'h1FFF);
        run_random_phase(60);
        write_stream_length(13'd24);
        run_random_phase(80);
        write_stream_length(LEN_W'(LEN_RESET));
        run_random_phase(60);
        write_stream_length(13'd5);
        run_random_phase(40);
        write_stream_length(LEN_W'($urandom_range(2, 64)));
        run_random_phase(90);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
